// ===== sv/packet_fifo_dedup_range_count_core_assert.svh =====
// Assertion macros for the packet FIFO dedup / range count block
`ifndef PACKET_FIFO_DEDUP_RANGE_COUNT_CORE_ASSERT_SVH
`define PACKET_FIFO_DEDUP_RANGE_COUNT_CORE_ASSERT_SVH

// clocked on clk_i, masked while rst_ni is low
`define PFD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// clocked on clk_i, also checked during reset
`define PFD_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== sv/pfd_pkg.sv =====
// Shared types, constants and helpers for the packet FIFO dedup / range count block
package pfd_pkg;

  localparam int QueueDepth = 64;
  localparam int NodeW      = 16;
  localparam int TimeW      = 32;
  localparam int PtrW       = $clog2(QueueDepth);
  localparam int OccW       = $clog2(QueueDepth + 1);
  localparam int CapW       = 7;
  localparam int OpW        = 2;
  localparam int StatusW    = 2;

  localparam logic [OpW-1:0] OpAdd     = 2'd0;
  localparam logic [OpW-1:0] OpForward = 2'd1;
  localparam logic [OpW-1:0] OpCount   = 2'd2;

  localparam logic [StatusW-1:0] StatusDone  = 2'd0;
  localparam logic [StatusW-1:0] StatusDup   = 2'd1;
  localparam logic [StatusW-1:0] StatusEmpty = 2'd2;

  localparam logic [CapW-1:0] CapReset = CapW'(QueueDepth);

  typedef struct packed {
    logic [NodeW-1:0] src;
    logic [NodeW-1:0] dst;
    logic [TimeW-1:0] ts;
  } entry_t;

  typedef struct packed {
    entry_t           pkt;
    logic [TimeW-1:0] lo;
    logic [TimeW-1:0] hi;
  } key_t;

  typedef struct packed {
    logic exact;
    logic in_range;
  } match_t;

  function automatic logic [PtrW-1:0] next_slot(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(QueueDepth - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== sv/pfd_store.sv =====
// Entry store: one write port, one read port with registered read data
module pfd_store
  import pfd_pkg::*;
(
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [PtrW-1:0] waddr_i,
  input  entry_t          wdata_i,
  input  logic            re_i,
  input  logic [PtrW-1:0] raddr_i,
  output entry_t          rdata_o
);

  entry_t mem [QueueDepth];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rd_data_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rd_data_q;

endmodule

// ===== sv/pfd_match.sv =====
// Shared compare unit: exact triple match and destination/time-window match
module pfd_match
  import pfd_pkg::*;
(
  input  entry_t entry_i,
  input  key_t   key_i,
  output match_t match_o
);

  logic dst_eq;

  assign dst_eq = (entry_i.dst == key_i.pkt.dst);

  always_comb begin
    match_o.exact    = dst_eq && (entry_i.src == key_i.pkt.src) &&
                       (entry_i.ts == key_i.pkt.ts);
    match_o.in_range = dst_eq && (entry_i.ts >= key_i.lo) && (entry_i.ts <= key_i.hi);
  end

endmodule

// ===== sv/packet_fifo_dedup_range_count_core.sv =====
// Bounded packet FIFO with duplicate filter and range counter, top level
// One transaction at a time. Add and count scan the stored packets through the
// read port of the entry store, one entry per cycle, and the result is then
// loaded into the output register once it is free. Forward reads only the head,
// and the unused opcode 3 reads nothing.
// The input stalls while a transaction is in work; a finished result sits in
// an output register, so the next transaction can be accepted while it waits.
// Capacity may only be written while no transaction is in work.
module packet_fifo_dedup_range_count_core
  import pfd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CapW-1:0]     cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [OpW-1:0]      opcode_i,
  input  logic [NodeW-1:0]    source_i,
  input  logic [NodeW-1:0]    destination_i,
  input  logic [TimeW-1:0]    timestamp_i,
  input  logic [TimeW-1:0]    start_time_i,
  input  logic [TimeW-1:0]    end_time_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [StatusW-1:0]  status_o,
  output logic [NodeW-1:0]    out_source_o,
  output logic [NodeW-1:0]    out_destination_o,
  output logic [TimeW-1:0]    out_timestamp_o,
  output logic [OccW-1:0]     match_count_o
);

`include "packet_fifo_dedup_range_count_core_assert.svh"

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_RESULT = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [CapW-1:0]  capacity_q;
  logic [PtrW-1:0]  head_q, tail_q, rd_ptr_q;
  logic [OccW-1:0]  occ_q, issue_q, len_q, cnt_q, eff_cap;
  logic             rd_vld_q, dup_q, out_valid_q;
  logic [OpW-1:0]   op_q;
  key_t             key_q;

  logic [StatusW-1:0] status_q;
  entry_t             out_pkt_q;
  logic [OccW-1:0]    out_cnt_q;

  logic   in_accept, rd_en, scan_done, out_load, fwd_hit, add_commit;
  entry_t rd_entry, new_entry;
  match_t match;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;

  // 0 behaves as 1, anything above the store depth as the depth
  always_comb begin
    if (capacity_q == '0) begin
      eff_cap = OccW'(1);
    end else if (capacity_q > CapW'(QueueDepth)) begin
      eff_cap = OccW'(QueueDepth);
    end else begin
      eff_cap = OccW'(capacity_q);
    end
  end

  assign rd_en     = (state_q == ST_SCAN) && (issue_q < len_q);
  assign scan_done = (state_q == ST_SCAN) && (issue_q == len_q) && !rd_vld_q;
  assign out_load  = (state_q == ST_RESULT) && (!out_valid_q || !out_stall_i);
  assign fwd_hit   = (op_q == OpForward) && (occ_q != '0);
  assign add_commit = out_load && (op_q == OpAdd) && !dup_q;

  assign new_entry = key_q.pkt;

  pfd_store u_store (
    .clk_i   (clk_i),
    .we_i    (add_commit),
    .waddr_i (tail_q),
    .wdata_i (new_entry),
    .re_i    (rd_en),
    .raddr_i (rd_ptr_q),
    .rdata_o (rd_entry)
  );

  pfd_match u_match (
    .entry_i (rd_entry),
    .key_i   (key_q),
    .match_o (match)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      capacity_q  <= CapReset;
      head_q      <= '0;
      tail_q      <= '0;
      occ_q       <= '0;
      issue_q     <= '0;
      len_q       <= '0;
      rd_ptr_q    <= '0;
      rd_vld_q    <= 1'b0;
      dup_q       <= 1'b0;
      cnt_q       <= '0;
      op_q        <= OpAdd;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_en;

      if (cfg_valid_i && cfg_ready_o) begin
        capacity_q <= cfg_data_i;
      end

      if (in_accept) begin
        op_q     <= opcode_i;
        rd_ptr_q <= head_q;
        issue_q  <= '0;
        dup_q    <= 1'b0;
        cnt_q    <= '0;
        // forward reads only the head; opcode 3 reads nothing
        case (opcode_i)
          OpAdd, OpCount: len_q <= occ_q;
          OpForward:      len_q <= (occ_q != '0) ? OccW'(1) : '0;
          default:        len_q <= '0;
        endcase
      end

      if (rd_en) begin
        rd_ptr_q <= next_slot(rd_ptr_q);
        issue_q  <= issue_q + 1'b1;
      end

      if (rd_vld_q) begin
        if (match.exact) begin
          dup_q <= 1'b1;
        end
        if (match.in_range) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end

      if (add_commit) begin
        tail_q <= next_slot(tail_q);
        if (occ_q >= eff_cap) begin
          head_q <= next_slot(head_q);
        end else begin
          occ_q <= occ_q + 1'b1;
        end
      end else if (out_load && fwd_hit) begin
        head_q <= next_slot(head_q);
        occ_q  <= occ_q - 1'b1;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      key_q.pkt.src <= source_i;
      key_q.pkt.dst <= destination_i;
      key_q.pkt.ts  <= timestamp_i;
      key_q.lo      <= start_time_i;
      key_q.hi      <= end_time_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      case (op_q)
        OpAdd: begin
          status_q  <= dup_q ? StatusDup : StatusDone;
          out_pkt_q <= '0;
          out_cnt_q <= '0;
        end
        OpForward: begin
          status_q  <= fwd_hit ? StatusDone : StatusEmpty;
          out_pkt_q <= fwd_hit ? rd_entry : '0;
          out_cnt_q <= '0;
        end
        OpCount: begin
          status_q  <= StatusDone;
          out_pkt_q <= '0;
          out_cnt_q <= cnt_q;
        end
        default: begin
          status_q  <= StatusDone;
          out_pkt_q <= '0;
          out_cnt_q <= '0;
        end
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign out_source_o      = out_pkt_q.src;
  assign out_destination_o = out_pkt_q.dst;
  assign out_timestamp_o   = out_pkt_q.ts;
  assign match_count_o     = out_cnt_q;

  `PFD_ASSERT_ALWAYS(a_occ_bound, occ_q <= OccW'(QueueDepth), "occupancy above store depth")
  `PFD_ASSERT(a_ptr_occ, PtrW'(tail_q - head_q) == PtrW'(occ_q), "head/tail vs occupancy")
  `PFD_ASSERT(a_issue_bound, issue_q <= len_q, "scan issued past its length")
  `PFD_ASSERT(a_stall_after_accept, in_accept |=> in_stall_o, "input not stalled while busy")
  `PFD_ASSERT(a_dup_only_add, (out_load && dup_q && op_q != OpAdd) |=> (status_q != StatusDup), "dup on non-add")

endmodule
